>>> rtl/cqir_pkg.sv
// Shared types and codes for the collapsing queue with indexed remove.
`timescale 1ns / 1ps

package cqir_pkg;

   // operation codes
   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NULL  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  slot_index;
      logic [31:0] element_in;
   } req_type;

   typedef struct packed {
      logic [31:0] element_out;
      logic [1:0]  status;
      logic [4:0]  fill_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch_req;
      logic       put_write;
      logic       clear;
      logic       read_idx;
      logic       capture_rd;
      logic       shift_rd;
      logic       shift_wr;
      logic       dec_count;
      logic       set_status;
      logic [1:0] status;
      logic       load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       is_null;
      logic       is_full;
      logic       in_range;
      logic       more_shift;
      logic       rsp_free;
   } sts_type;

endpackage

>>> rtl/cqir_dp.sv
// Datapath: entry memory, occupancy count, move pointer and result word register.
`timescale 1ns / 1ps

module cqir_dp #(
   parameter int DEPTH         = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cqir_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cqir_pkg::rsp_type rsp_data,
   input  cqir_pkg::cmd_type cmd,
   output cqir_pkg::sts_type sts
);
   import cqir_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;

   logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

   logic [1:0]               op_ff;
   logic [3:0]               idx_ff;
   logic [ELEMENT_WIDTH-1:0] word_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            ptr_ff;
   logic [ELEMENT_WIDTH-1:0] rd_data_ff;
   logic [ELEMENT_WIDTH-1:0] res_elem_ff;
   logic [1:0]               res_status_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic                     mem_we, mem_re;
   logic [AW-1:0]            waddr, raddr;
   logic [ELEMENT_WIDTH-1:0] wdata;
   logic [CW-1:0]            ptr_next;

   assign ptr_next = CW'(ptr_ff) + CW'(1);

   // memory port selection
   always_comb begin
      mem_we = cmd.put_write | cmd.shift_wr;
      mem_re = cmd.read_idx | cmd.shift_rd;
      waddr  = cmd.put_write ? AW'(count_ff) : ptr_ff;
      wdata  = cmd.put_write ? word_ff : rd_data_ff;
      raddr  = cmd.read_idx ? AW'(idx_ff) : AW'(ptr_next);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.put_write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff       <= req_data.op;
         idx_ff      <= req_data.slot_index;
         word_ff     <= ELEMENT_WIDTH'(req_data.element_in);
         res_elem_ff <= '0;
      end else if (cmd.capture_rd) begin
         res_elem_ff <= rd_data_ff;
      end
      if (cmd.read_idx) begin
         ptr_ff <= AW'(idx_ff);
      end else if (cmd.shift_wr) begin
         ptr_ff <= AW'(ptr_next);
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.load_rsp) begin
         rsp_ff.element_out <= 32'(res_elem_ff);
         rsp_ff.status      <= res_status_ff;
         rsp_ff.fill_count  <= 5'(count_ff);
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.is_null    = (word_ff == '0);
      sts.is_full    = (count_ff == CW'(DEPTH));
      sts.in_range   = (CMPW'(idx_ff) < CMPW'(count_ff));
      sts.more_shift = (ptr_next < count_ff);
      sts.rsp_free   = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten while waiting");

   a_put_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.put_write |-> (count_ff < CW'(DEPTH)))
      else $error("write to full store");

   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> (ptr_next < count_ff))
      else $error("collapse move beyond occupancy");

endmodule

>>> rtl/cqir_ctrl.sv
// Controller: sequences accept, decode, memory read, collapse moves and result load.
`timescale 1ns / 1ps

module cqir_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output cqir_pkg::cmd_type cmd,
   input  cqir_pkg::sts_type sts
);
   import cqir_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_in       = S_FINISH;
            unique case (sts.op) inside
               OP_PUT: begin
                  if (sts.is_null) begin
                     cmd.status = ST_NULL;
                  end else if (sts.is_full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.put_write = 1'b1;
                  end
               end
               OP_REMOVE, OP_PEEK: begin
                  if (!sts.in_range) begin
                     cmd.status = ST_RANGE;
                  end else begin
                     cmd.read_idx = 1'b1;
                     state_in     = S_RD_WAIT;
                  end
               end
               default: begin
                  cmd.clear = 1'b1;
               end
            endcase
         end
         S_RD_WAIT: begin
            cmd.capture_rd = 1'b1;
            state_in       = (sts.op == OP_REMOVE) ? S_SHIFT_RD : S_FINISH;
         end
         S_SHIFT_RD: begin
            if (sts.more_shift) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.dec_count = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/collapsing_queue_indexed_remove_core.sv
// Top level of the collapsing queue with indexed remove.
// Steps per word: put, clear and refused ops pass idle, decode and finish; peek adds a
//   read wait; a remove at index i with n entries also moves each of the n-1-i later
//   entries down by one read and one write on the entry memory.
// The result word is registered and is valid in the cycle after the op's final state.
// Reset clears the occupancy and the control state; entries are not cleared.
`timescale 1ns / 1ps

module collapsing_queue_indexed_remove_core #(
   parameter int DEPTH         = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cqir_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cqir_pkg::rsp_type rsp_data
);
   import cqir_pkg::*;

   // Command and status between the sequencer and the datapath.
   cmd_type cmd;
   sts_type sts;

   // The controller takes a word only when idle; the result sits in an
   // output register, so the next word is taken while it waits for rsp_ready.
   cqir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath holds the entry memory, the count and the collapse pointer.
   cqir_dp #(
      .DEPTH         (DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
